/* rtl/ptpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpc_pkg
// Shared defaults and types for the pulse train peak capture block.
// ----------------------------------------------------------------------------
package ptpc_pkg;

    // default configuration of the block
    localparam int SENSOR_BITS_DEF = 16;
    localparam int US_PER_MS_DEF   = 1000;

    // control for one peak tracker: clear to zero, restart from the
    // current reading, or keep the larger deviation
    typedef struct packed {
        logic clear;
        logic restart;
        logic track;
    } peak_ctl_t;

endpackage

/* rtl/pulse_train_peak_capture.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_train_peak_capture
// Actuator test sequencer: pre-delay, pwm pulses and recovery gaps, with
// per-pulse peak deviation capture for two hall sensors.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | beat
//  in      | input     | in_valid / in_stall  | cmd, now_us, hall_low_mv, hall_high_mv
//  out     | output    | out_valid / out_stall| status, pwm, phase, pulse, peaks, deltas
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  one beat in gives one beat out; a beat can enter on every cycle while the output beat is not stalled
//  a beat passes the input register, then the sequencer state, which is
//  also the output register
//  the input register is held while the output beat is stalled
//  rst_n clears the sequencer to stopped and loads the register defaults
//  configuration writes are always taken (cfg_ready is tied high)
// ----------------------------------------------------------------------------
module pulse_train_peak_capture
    import ptpc_pkg::*;
#(
    parameter int SENSOR_BITS = SENSOR_BITS_DEF,
    parameter int US_PER_MS   = US_PER_MS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // sample / command channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  cmd,
    input  logic [31:0]                 now_us,
    input  logic [SENSOR_BITS-1:0]      hall_low_mv,
    input  logic [SENSOR_BITS-1:0]      hall_high_mv,
    // status channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        run_active,
    output logic                        run_finished,
    output logic [7:0]                  pwm_level,
    output logic [2:0]                  phase_code,
    output logic [7:0]                  pulse_number,
    output logic [SENSOR_BITS-1:0]      peak_low_mv,
    output logic [SENSOR_BITS-1:0]      peak_high_mv,
    output logic signed [SENSOR_BITS:0] peak_low_delta,
    output logic signed [SENSOR_BITS:0] peak_high_delta,
    // configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_index,
    input  logic [15:0]                 cfg_data
);

    // millisecond limits are held as microsecond thresholds, so that
    // elapsed / US_PER_MS >= limit becomes elapsed >= limit * US_PER_MS
    localparam int THR_W = 16 + $clog2(US_PER_MS + 1);
    localparam int CMP_W = (THR_W > 32) ? THR_W : 32;

    // register indexes
    localparam logic [2:0] REG_PULSE_COUNT = 3'd0;
    localparam logic [2:0] REG_PULSE_LEVEL = 3'd1;
    localparam logic [2:0] REG_PULSE_TIME  = 3'd2;
    localparam logic [2:0] REG_GAP_TIME    = 3'd3;
    localparam logic [2:0] REG_PRE_DELAY   = 3'd4;

    // register defaults
    localparam logic [7:0]       PULSE_COUNT_RST = 8'd10;
    localparam logic [7:0]       PULSE_LEVEL_RST = 8'd200;
    localparam logic [THR_W-1:0] PULSE_THR_RST   = THR_W'(30 * US_PER_MS);
    localparam logic [THR_W-1:0] GAP_THR_RST     = THR_W'(1000 * US_PER_MS);

    // commands
    localparam logic [1:0] CMD_UPDATE = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;

    // sequencer phases
    localparam logic [2:0] PH_STOP  = 3'd0;
    localparam logic [2:0] PH_PRE   = 3'd1;
    localparam logic [2:0] PH_PULSE = 3'd2;
    localparam logic [2:0] PH_GAP   = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [7:0]       count_reg;      // zero already mapped to one
    logic [7:0]       level_reg;
    logic [THR_W-1:0] pulse_thr_reg;  // zero already mapped to one ms
    logic [THR_W-1:0] gap_thr_reg;
    logic [THR_W-1:0] pre_thr_reg;

    logic [15:0]      cfg_ms;
    logic [THR_W-1:0] cfg_thr;

    assign cfg_ready = 1'b1;

    // pulse time of zero is read as one ms
    assign cfg_ms  = ((cfg_index == REG_PULSE_TIME) && (cfg_data == 16'd0)) ?
                     16'd1 : cfg_data;
    assign cfg_thr = THR_W'(cfg_ms) * THR_W'(US_PER_MS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= PULSE_COUNT_RST;
            level_reg     <= PULSE_LEVEL_RST;
            pulse_thr_reg <= PULSE_THR_RST;
            gap_thr_reg   <= GAP_THR_RST;
            pre_thr_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PULSE_COUNT: count_reg     <= (cfg_data[7:0] == 8'd0) ?
                                                  8'd1 : cfg_data[7:0];
                REG_PULSE_LEVEL: level_reg     <= cfg_data[7:0];
                REG_PULSE_TIME:  pulse_thr_reg <= cfg_thr;
                REG_GAP_TIME:    gap_thr_reg   <= cfg_thr;
                REG_PRE_DELAY:   pre_thr_reg   <= cfg_thr;
                default:         ;  // unknown index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register and handshake
    // ------------------------------------------------------------------
    logic                   s1_valid_reg;
    logic [1:0]             s1_cmd_reg;
    logic [31:0]            s1_now_reg;
    logic [SENSOR_BITS-1:0] s1_lo_reg;
    logic [SENSOR_BITS-1:0] s1_hi_reg;
    logic                   out_valid_reg;
    logic                   advance;
    logic                   in_accept;

    // state moves on when the status slot is free or being taken
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg <= cmd;
            s1_now_reg <= now_us;
            s1_lo_reg  <= hall_low_mv;
            s1_hi_reg  <= hall_high_mv;
        end
    end

    // ------------------------------------------------------------------
    // sequencer state, shown directly on the status beat
    // ------------------------------------------------------------------
    logic [2:0]                  phase_reg,   phase_next;
    logic                        active_reg,  active_next;
    logic                        finished_reg, finished_next;
    logic [7:0]                  pwm_reg,     pwm_next;
    logic [7:0]                  count_cur_reg, count_cur_next;
    logic [31:0]                 stamp_reg,   stamp_next;
    logic [SENSOR_BITS-1:0]      base_lo_reg, base_lo_next;
    logic [SENSOR_BITS-1:0]      base_hi_reg, base_hi_next;
    logic [SENSOR_BITS-1:0]      peak_lo_reg, peak_lo_next;
    logic [SENSOR_BITS-1:0]      peak_hi_reg, peak_hi_next;
    logic signed [SENSOR_BITS:0] delta_lo_reg, delta_lo_next;
    logic signed [SENSOR_BITS:0] delta_hi_reg, delta_hi_next;
    peak_ctl_t                   peak_ctl;

    // phase timer: one subtract and compare against the selected limit
    logic [THR_W-1:0] thr_sel;
    logic [31:0]      elapsed_us;
    logic             time_up;

    always_comb
    begin
        case (phase_reg)
            PH_PRE:   thr_sel = pre_thr_reg;
            PH_PULSE: thr_sel = pulse_thr_reg;
            default:  thr_sel = gap_thr_reg;
        endcase
    end

    assign elapsed_us = s1_now_reg - stamp_reg;

    // a phase started at stamp zero reads elapsed zero
    assign time_up = (stamp_reg == 32'd0) ? (thr_sel == '0) :
                     (CMP_W'(elapsed_us) >= CMP_W'(thr_sel));

    always_comb
    begin
        phase_next     = phase_reg;
        active_next    = active_reg;
        finished_next  = finished_reg;
        pwm_next       = pwm_reg;
        count_cur_next = count_cur_reg;
        stamp_next     = stamp_reg;
        base_lo_next   = base_lo_reg;
        base_hi_next   = base_hi_reg;
        peak_ctl       = '0;

        unique case (s1_cmd_reg)
            CMD_START:
            begin
                // fresh run: baselines from this beat
                finished_next = 1'b0;
                active_next   = 1'b1;
                base_lo_next  = s1_lo_reg;
                base_hi_next  = s1_hi_reg;
                stamp_next    = s1_now_reg;
                peak_ctl.clear = 1'b1;
                if (pre_thr_reg != '0)
                begin
                    phase_next     = PH_PRE;
                    pwm_next       = 8'd0;
                    count_cur_next = 8'd0;
                end
                else
                begin
                    // first pulse at once, deltas of zero
                    phase_next       = PH_PULSE;
                    pwm_next         = level_reg;
                    count_cur_next   = 8'd1;
                    peak_ctl.restart = 1'b1;
                end
            end
            CMD_STOP:
            begin
                phase_next     = PH_STOP;
                active_next    = 1'b0;
                finished_next  = 1'b0;
                pwm_next       = 8'd0;
                count_cur_next = 8'd0;
                stamp_next     = 32'd0;
                base_lo_next   = '0;
                base_hi_next   = '0;
                peak_ctl.clear = 1'b1;
            end
            CMD_UPDATE:
            begin
                if (active_reg)
                begin
                    unique case (phase_reg)
                        PH_PRE:
                        begin
                            pwm_next = 8'd0;
                            if (time_up)
                            begin
                                phase_next       = PH_PULSE;
                                stamp_next       = s1_now_reg;
                                pwm_next         = level_reg;
                                peak_ctl.restart = 1'b1;
                                if (count_cur_reg < count_reg)
                                    count_cur_next = count_cur_reg + 8'd1;
                            end
                        end
                        PH_PULSE:
                        begin
                            pwm_next       = level_reg;
                            peak_ctl.track = 1'b1;
                            if (time_up)
                            begin
                                pwm_next   = 8'd0;
                                phase_next = PH_GAP;
                                stamp_next = s1_now_reg;
                            end
                        end
                        PH_GAP:
                        begin
                            pwm_next       = 8'd0;
                            peak_ctl.track = 1'b1;
                            if (time_up)
                            begin
                                stamp_next = s1_now_reg;
                                if (count_cur_reg >= count_reg)
                                begin
                                    active_next   = 1'b0;
                                    finished_next = 1'b1;
                                    phase_next    = PH_DONE;
                                end
                                else
                                begin
                                    // next pulse, peaks restart here
                                    phase_next       = PH_PULSE;
                                    pwm_next         = level_reg;
                                    peak_ctl.restart = 1'b1;
                                    count_cur_next   = count_cur_reg + 8'd1;
                                end
                            end
                        end
                        default: ;  // stopped or finished: hold
                    endcase
                end
            end
            default: ;  // unused command, state held
        endcase
    end

    ptpc_peak #(
        .SENSOR_BITS (SENSOR_BITS)
    ) u_peak_lo (
        .ctl          (peak_ctl),
        .reading      (s1_lo_reg),
        .base         (base_lo_next),
        .peak_mv      (peak_lo_reg),
        .delta        (delta_lo_reg),
        .peak_mv_next (peak_lo_next),
        .delta_next   (delta_lo_next)
    );

    ptpc_peak #(
        .SENSOR_BITS (SENSOR_BITS)
    ) u_peak_hi (
        .ctl          (peak_ctl),
        .reading      (s1_hi_reg),
        .base         (base_hi_next),
        .peak_mv      (peak_hi_reg),
        .delta        (delta_hi_reg),
        .peak_mv_next (peak_hi_next),
        .delta_next   (delta_hi_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_STOP;
            active_reg    <= 1'b0;
            finished_reg  <= 1'b0;
            pwm_reg       <= 8'd0;
            count_cur_reg <= 8'd0;
            stamp_reg     <= 32'd0;
            base_lo_reg   <= '0;
            base_hi_reg   <= '0;
            peak_lo_reg   <= '0;
            peak_hi_reg   <= '0;
            delta_lo_reg  <= '0;
            delta_hi_reg  <= '0;
        end
        else if (advance && s1_valid_reg)
        begin
            phase_reg     <= phase_next;
            active_reg    <= active_next;
            finished_reg  <= finished_next;
            pwm_reg       <= pwm_next;
            count_cur_reg <= count_cur_next;
            stamp_reg     <= stamp_next;
            base_lo_reg   <= base_lo_next;
            base_hi_reg   <= base_hi_next;
            peak_lo_reg   <= peak_lo_next;
            peak_hi_reg   <= peak_hi_next;
            delta_lo_reg  <= delta_lo_next;
            delta_hi_reg  <= delta_hi_next;
        end
    end

    // status beat
    assign out_valid       = out_valid_reg;
    assign run_active      = active_reg;
    assign run_finished    = finished_reg;
    assign pwm_level       = pwm_reg;
    assign phase_code      = phase_reg;
    assign pulse_number    = count_cur_reg;
    assign peak_low_mv     = peak_lo_reg;
    assign peak_high_mv    = peak_hi_reg;
    assign peak_low_delta  = delta_lo_reg;
    assign peak_high_delta = delta_hi_reg;

endmodule

/* rtl/ptpc_peak.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpc_peak
// Peak deviation tracker for one sensor: next reading and signed delta.
// ----------------------------------------------------------------------------
module ptpc_peak
    import ptpc_pkg::*;
#(
    parameter int SENSOR_BITS = SENSOR_BITS_DEF
)
(
    input  peak_ctl_t                ctl,
    input  logic [SENSOR_BITS-1:0]   reading,
    input  logic [SENSOR_BITS-1:0]   base,
    input  logic [SENSOR_BITS-1:0]   peak_mv,
    input  logic signed [SENSOR_BITS:0] delta,
    output logic [SENSOR_BITS-1:0]   peak_mv_next,
    output logic signed [SENSOR_BITS:0] delta_next
);

    logic signed [SENSOR_BITS:0] dev;
    logic [SENSOR_BITS:0]        mag_dev;
    logic [SENSOR_BITS:0]        mag_old;

    assign dev     = $signed({1'b0, reading}) - $signed({1'b0, base});
    assign mag_dev = dev[SENSOR_BITS] ? (~dev + 1'b1) : dev;
    assign mag_old = delta[SENSOR_BITS] ? (~delta + 1'b1) : delta;

    always_comb
    begin
        peak_mv_next = peak_mv;
        delta_next   = delta;
        if (ctl.restart)
        begin
            peak_mv_next = reading;
            delta_next   = dev;
        end
        else if (ctl.clear)
        begin
            peak_mv_next = '0;
            delta_next   = '0;
        end
        else if (ctl.track && (mag_dev >= mag_old))
        begin
            // ties go to the later sample
            peak_mv_next = reading;
            delta_next   = dev;
        end
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the pulse train peak capture block against a cycle-free predictor
// of its sequencer: directed idle, default-run and register-extreme cases,
// then randomised pulse trains under several sender and receiver idling
// mixes. Every status beat is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
    import ptpc_pkg::*;

    localparam int SB = SENSOR_BITS_DEF;

    // command codes of the sample channel
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // sequencer phases as reported on phase_code
    localparam logic [2:0] PH_STOPPED    = 3'd0;
    localparam logic [2:0] PH_PRE_DELAY  = 3'd1;
    localparam logic [2:0] PH_PULSING    = 3'd2;
    localparam logic [2:0] PH_RECOVERING = 3'd3;
    localparam logic [2:0] PH_FINISHED   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_PULSE_COUNT = 3'd0;
    localparam logic [2:0] REG_PULSE_LEVEL = 3'd1;
    localparam logic [2:0] REG_PULSE_TIME  = 3'd2;
    localparam logic [2:0] REG_GAP_TIME    = 3'd3;
    localparam logic [2:0] REG_PRE_DELAY   = 3'd4;

    // one status beat as the block should report it
    typedef struct packed {
        logic          active;
        logic          finished;
        logic [7:0]    pwm;
        logic [2:0]    phase;
        logic [7:0]    pulse;
        logic [SB-1:0] peak_lo;
        logic [SB-1:0] peak_hi;
        logic [SB:0]   dev_lo;
        logic [SB:0]   dev_hi;
    } status_t;

    // ------------------------------------------------------------------------
    // clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------------
    logic          clk          = 1'b0;
    logic          rst_n        = 1'b0;
    logic          in_valid     = 1'b0;
    logic [1:0]    cmd          = CMD_SAMPLE;
    logic [31:0]   now_us       = '0;
    logic [SB-1:0] hall_low_mv  = '0;
    logic [SB-1:0] hall_high_mv = '0;
    logic          out_stall    = 1'b0;
    logic          cfg_valid    = 1'b0;
    logic [2:0]    cfg_index    = REG_PULSE_COUNT;
    logic [15:0]   cfg_data     = '0;

    logic                 in_stall;
    logic                 out_valid;
    logic                 run_active;
    logic                 run_finished;
    logic [7:0]           pwm_level;
    logic [2:0]           phase_code;
    logic [7:0]           pulse_number;
    logic [SB-1:0]        peak_low_mv;
    logic [SB-1:0]        peak_high_mv;
    logic signed [SB:0]   peak_low_delta;
    logic signed [SB:0]   peak_high_delta;
    logic                 cfg_ready;

    always #5 clk = ~clk;

    pulse_train_peak_capture dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .now_us          (now_us),
        .hall_low_mv     (hall_low_mv),
        .hall_high_mv    (hall_high_mv),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .run_active      (run_active),
        .run_finished    (run_finished),
        .pwm_level       (pwm_level),
        .phase_code      (phase_code),
        .pulse_number    (pulse_number),
        .peak_low_mv     (peak_low_mv),
        .peak_high_mv    (peak_high_mv),
        .peak_low_delta  (peak_low_delta),
        .peak_high_delta (peak_high_delta),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // ------------------------------------------------------------------------
    // bookkeeping
    // ------------------------------------------------------------------------
    status_t     pending_status[$];   // status beats still owed by the block
    int          fail_count  = 0;
    int          sent_beats  = 0;     // every beat taken by the block
    int          idle_pct    = 35;    // sender gap probability, percent
    int          stall_pct   = 55;    // receiver stall probability, percent
    logic [31:0] clock_us    = 32'd1000;

    // ------------------------------------------------------------------------
    // predictor: register copy and sequencer state
    // ------------------------------------------------------------------------
    logic [7:0]    pulses_per_run;
    logic [7:0]    duty_level;
    logic [15:0]   pulse_len_ms;
    logic [15:0]   gap_len_ms;
    logic [15:0]   pre_wait_ms;

    logic [2:0]    seq_phase;
    logic          seq_active;
    logic          seq_finished;
    logic [7:0]    seq_pwm;
    logic [7:0]    seq_pulse;
    logic [31:0]   seq_stamp;
    logic [SB-1:0] base_lo;
    logic [SB-1:0] base_hi;
    logic [SB-1:0] pk_lo;
    logic [SB-1:0] pk_hi;
    int            dev_lo;
    int            dev_hi;

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int unsigned runs_wanted();
        return (pulses_per_run == 8'd0) ? 1 : pulses_per_run;
    endfunction

    function automatic int unsigned pulse_wanted_ms();
        return (pulse_len_ms == 16'd0) ? 1 : pulse_len_ms;
    endfunction

    // wrapping time since the phase began, whole ms; a zero stamp reads zero
    function automatic int unsigned phase_elapsed_ms(logic [31:0] now);
        logic [31:0] diff;
        if (seq_stamp == 32'd0)
            return 0;
        diff = now - seq_stamp;
        return diff / US_PER_MS_DEF;
    endfunction

    function automatic void clear_sequencer();
        seq_phase    = PH_STOPPED;
        seq_active   = 1'b0;
        seq_finished = 1'b0;
        seq_pwm      = '0;
        seq_pulse    = '0;
        seq_stamp    = '0;
        base_lo      = '0;
        base_hi      = '0;
        pk_lo        = '0;
        pk_hi        = '0;
        dev_lo       = 0;
        dev_hi       = 0;
    endfunction

    function automatic void load_defaults();
        pulses_per_run = 8'd10;
        duty_level     = 8'd200;
        pulse_len_ms   = 16'd30;
        gap_len_ms     = 16'd1000;
        pre_wait_ms    = 16'd0;
        clear_sequencer();
    endfunction

    function automatic void load_register(logic [2:0] idx, logic [15:0] data);
        case (idx)
            REG_PULSE_COUNT: pulses_per_run = data[7:0];
            REG_PULSE_LEVEL: duty_level     = data[7:0];
            REG_PULSE_TIME:  pulse_len_ms   = data;
            REG_GAP_TIME:    gap_len_ms     = data;
            REG_PRE_DELAY:   pre_wait_ms    = data;
            default: ;
        endcase
    endfunction

    // new pulse: count up (saturating), peaks restart from the current reading
    function automatic void open_pulse(logic [31:0] now, logic [SB-1:0] lo,
                                       logic [SB-1:0] hi);
        if (seq_pulse < runs_wanted())
            seq_pulse = seq_pulse + 8'd1;
        pk_lo     = lo;
        pk_hi     = hi;
        dev_lo    = int'(lo) - int'(base_lo);
        dev_hi    = int'(hi) - int'(base_hi);
        seq_pwm   = duty_level;
        seq_phase = PH_PULSING;
        seq_stamp = now;
    endfunction

    // keep the largest deviation; equal magnitude goes to the later reading
    function automatic void follow_peaks(logic [SB-1:0] lo, logic [SB-1:0] hi);
        int dl;
        int dh;
        dl = int'(lo) - int'(base_lo);
        dh = int'(hi) - int'(base_hi);
        if (magnitude(dl) >= magnitude(dev_lo))
        begin
            dev_lo = dl;
            pk_lo  = lo;
        end
        if (magnitude(dh) >= magnitude(dev_hi))
        begin
            dev_hi = dh;
            pk_hi  = hi;
        end
    endfunction

    function automatic status_t advance_sequencer(logic [1:0] op, logic [31:0] now,
                                                  logic [SB-1:0] lo, logic [SB-1:0] hi);
        status_t s;
        if (op == CMD_START)
        begin
            clear_sequencer();
            seq_active = 1'b1;
            base_lo    = lo;
            base_hi    = hi;
            if (pre_wait_ms != 16'd0)
            begin
                seq_phase = PH_PRE_DELAY;
                seq_stamp = now;
            end
            else
                open_pulse(now, lo, hi);
        end
        else if (op == CMD_STOP)
            clear_sequencer();
        else if (op == CMD_SAMPLE && seq_active)
        begin
            if (seq_phase == PH_PRE_DELAY)
            begin
                seq_pwm = '0;
                if (phase_elapsed_ms(now) >= pre_wait_ms)
                    open_pulse(now, lo, hi);
            end
            else if (seq_phase == PH_PULSING)
            begin
                seq_pwm = duty_level;
                follow_peaks(lo, hi);
                if (phase_elapsed_ms(now) >= pulse_wanted_ms())
                begin
                    seq_pwm   = '0;
                    seq_phase = PH_RECOVERING;
                    seq_stamp = now;
                end
            end
            else if (seq_phase == PH_RECOVERING)
            begin
                seq_pwm = '0;
                follow_peaks(lo, hi);
                if (phase_elapsed_ms(now) >= gap_len_ms)
                begin
                    if (seq_pulse >= runs_wanted())
                    begin
                        seq_active   = 1'b0;
                        seq_finished = 1'b1;
                        seq_phase    = PH_FINISHED;
                        seq_stamp    = now;
                    end
                    else
                        open_pulse(now, lo, hi);
                end
            end
        end
        s.active   = seq_active;
        s.finished = seq_finished;
        s.pwm      = seq_pwm;
        s.phase    = seq_phase;
        s.pulse    = seq_pulse;
        s.peak_lo  = pk_lo;
        s.peak_hi  = pk_hi;
        s.dev_lo   = dev_lo[SB:0];
        s.dev_hi   = dev_hi[SB:0];
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // status checking: each accepted beat against the oldest prediction
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        status_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_status.size() == 0)
            begin
                $error("status beat with no prediction waiting");
                fail_count++;
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("run_active", 32'(want.active), 32'(run_active));
                check_field("run_finished", 32'(want.finished), 32'(run_finished));
                check_field("pwm_level", 32'(want.pwm), 32'(pwm_level));
                check_field("phase_code", 32'(want.phase), 32'(phase_code));
                check_field("pulse_number", 32'(want.pulse), 32'(pulse_number));
                check_field("peak_low_mv", 32'(want.peak_lo), 32'(peak_low_mv));
                check_field("peak_high_mv", 32'(want.peak_hi), 32'(peak_high_mv));
                check_field("peak_low_delta", 32'($signed(want.dev_lo)),
                            32'(peak_low_delta));
                check_field("peak_high_delta", 32'($signed(want.dev_hi)),
                            32'(peak_high_delta));
            end
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // ------------------------------------------------------------------------
    // drivers (called at a falling edge, return at a falling edge)
    // ------------------------------------------------------------------------
    task automatic send_beat(logic [1:0] op, logic [31:0] now,
                             logic [SB-1:0] lo, logic [SB-1:0] hi);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= op;
        now_us       <= now;
        hall_low_mv  <= lo;
        hall_high_mv <= hi;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sent_beats++;
        pending_status.push_back(advance_sequencer(op, now, lo, hi));
        @(negedge clk);
    endtask

    // stop sending, let every owed beat arrive, then cover the pipeline depth
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        load_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [SB-1:0] clip_reading(int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return '1;
        return v[SB-1:0];
    endfunction

    // sensor reading: extremes, baseline, a tie with the current peak
    // (mirrored or repeated) or a small excursion about the baseline
    function automatic logic [SB-1:0] pick_reading(logic [SB-1:0] base, int dev);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return base;
            3: return clip_reading(int'(base) - dev);
            4: return clip_reading(int'(base) + dev);
            default: return clip_reading(int'(base) + $urandom_range(0, 4000) - 2000);
        endcase
    endfunction

    function automatic logic [31:0] next_stamp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return clock_us;
        if (r < 85)
            return clock_us + $urandom_range(1, 1500);
        if (r < 95)
            return clock_us + $urandom_range(1500, 4000);
        return $urandom;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // nothing moves while stopped: updates at the field extremes, the spare
    // command and a stop all report the reset state
    task automatic test_idle_commands();
        send_beat(CMD_SAMPLE, 32'hFFFF_FFFF, '1, '1);
        send_beat(CMD_SAMPLE, 32'd0, '0, '0);
        send_beat(CMD_NONE, 32'h1234_5678, 16'hA5A5, 16'h5A5A);
        send_beat(CMD_STOP, 32'h8000_0000, 16'h5A5A, 16'hA5A5);
        wait_quiet();
    endtask

    // reset register values: pulse at once, 30 ms pulse, 1 s gap; ties in both
    // directions, a level change mid-run, then a stop
    task automatic test_default_run();
        send_beat(CMD_START, 32'd5000, 16'd1000, 16'd2000);
        send_beat(CMD_SAMPLE, 32'd15000, 16'd1500, 16'd1800);
        send_beat(CMD_SAMPLE, 32'd35000, 16'd500, 16'd2200);
        send_beat(CMD_SAMPLE, 32'd1_035_000, 16'd1100, 16'd1900);
        wait_quiet();
        // register change while a run is live takes effect on the next update
        write_register(REG_PULSE_LEVEL, 16'd17);
        send_beat(CMD_SAMPLE, 32'd1_040_000, 16'd900, 16'd2100);
        send_beat(CMD_STOP, 32'd1_041_000, 16'd0, 16'd0);
        wait_quiet();
    endtask

    // count of zero, zero pulse length, zero gap, longest pre-delay, full-scale
    // deviations, unused register indexes, zero stamp and timestamp wrap
    task automatic test_register_extremes();
        write_register(REG_PULSE_COUNT, 16'h1200);
        write_register(REG_PULSE_LEVEL, 16'hFFFF);
        write_register(REG_PULSE_TIME, 16'h0000);
        write_register(REG_GAP_TIME, 16'h0000);
        write_register(REG_PRE_DELAY, 16'hFFFF);
        write_register(3'd5, 16'hFFFF);
        write_register(3'd6, 16'hFFFF);
        write_register(3'd7, 16'hFFFF);
        send_beat(CMD_START, 32'd100, '0, '1);
        send_beat(CMD_SAMPLE, 32'd65_535_099, 16'd7, 16'd9);
        send_beat(CMD_SAMPLE, 32'd65_535_100, '1, '0);
        send_beat(CMD_SAMPLE, 32'd65_536_099, '0, '1);
        send_beat(CMD_SAMPLE, 32'd65_536_100, 16'd3, 16'd65530);
        send_beat(CMD_SAMPLE, 32'd65_536_100, 16'd4, 16'd4);
        send_beat(CMD_SAMPLE, 32'd99_999_999, '1, '1);
        wait_quiet();
        write_register(REG_PULSE_COUNT, 16'h00FF);
        write_register(REG_PULSE_LEVEL, 16'h0000);
        write_register(REG_PULSE_TIME, 16'd1);
        write_register(REG_GAP_TIME, 16'hFFFF);
        write_register(REG_PRE_DELAY, 16'h0000);
        // a phase stamped at zero does not time out unless its limit is zero
        send_beat(CMD_START, 32'd0, 16'd40000, 16'd20000);
        send_beat(CMD_SAMPLE, 32'hFFFF_FFFF, 16'd41000, 16'd19000);
        // elapsed time across the 32-bit wrap
        send_beat(CMD_START, 32'hFFFF_FE0C, 16'd30000, 16'd30000);
        send_beat(CMD_SAMPLE, 32'd500, 16'd29000, 16'd31000);
        send_beat(CMD_SAMPLE, 32'd900_000, 16'd30000, 16'd30000);
        send_beat(CMD_STOP, 32'd900_001, '1, '1);
        wait_quiet();
    endtask

    // one randomised train: fresh short timing, a start, then mostly updates
    // with advancing stamps; a little noise, restarts and stops
    task automatic run_train();
        int          n;
        int          r;
        logic [1:0]  op;
        logic [31:0] stamp;
        logic [SB-1:0] lo;
        logic [SB-1:0] hi;
        wait_quiet();
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 60)
            write_register(REG_PULSE_COUNT, (r < 10) ? 16'd0 :
                           (r < 20) ? 16'($urandom) : 16'($urandom_range(1, 4)));
        if ($urandom_range(0, 99) < 60)
            write_register(REG_PULSE_LEVEL, 16'($urandom));
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 60)
            write_register(REG_PULSE_TIME, (r < 5) ? 16'hFFFF :
                           (r < 8) ? 16'($urandom) : 16'($urandom_range(0, 3)));
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 60)
            write_register(REG_GAP_TIME, (r < 5) ? 16'hFFFF :
                           (r < 8) ? 16'($urandom) : 16'($urandom_range(0, 3)));
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 60)
            write_register(REG_PRE_DELAY, (r < 5) ? 16'hFFFF :
                           (r < 50) ? 16'd0 : 16'($urandom_range(1, 3)));
        if ($urandom_range(0, 99) < 5)
            write_register(3'($urandom_range(5, 7)), 16'($urandom));
        // now and then open the run on a zero stamp or just short of the wrap
        r = $urandom_range(0, 99);
        if (r < 8)
            clock_us = 32'd0;
        else if (r < 18)
            clock_us = 32'hFFFF_FFFF - $urandom_range(0, 5000);
        lo = ($urandom_range(0, 9) == 0) ? '0 : 16'($urandom);
        hi = ($urandom_range(0, 9) == 0) ? '1 : 16'($urandom);
        send_beat(CMD_START, clock_us, lo, hi);
        n = $urandom_range(5, 40);
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            op = (r < 3) ? CMD_NONE : (r < 5) ? CMD_STOP :
                 (r < 8) ? CMD_START : CMD_SAMPLE;
            stamp = next_stamp();
            clock_us = stamp;
            lo = pick_reading(base_lo, dev_lo);
            hi = pick_reading(base_hi, dev_hi);
            send_beat(op, stamp, lo, hi);
            if (op == CMD_STOP)
                break;
        end
    endtask

    // three idling mixes: slow receiver, then slow sender, then full rate
    task automatic test_random_trains();
        int target;
        for (int mix = 0; mix < 3; mix++)
        begin
            idle_pct  = (mix == 0) ? 35 : (mix == 1) ? 55 : 0;
            stall_pct = (mix == 0) ? 55 : (mix == 1) ? 35 : 0;
            target = sent_beats + 150;
            while (sent_beats < target)
                run_train();
        end
        wait_quiet();
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        load_defaults();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_commands();
        test_default_run();
        test_register_extremes();
        test_random_trains();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
rtl/ptpc_pkg.sv
rtl/ptpc_peak.sv
rtl/pulse_train_peak_capture.sv
test/testbench.sv
